// ===== rtl/wecr_pkg.sv =====
// ---------------------------------------------------------------------------
// wecr_pkg
// Types and constants shared by the energy counter accumulator modules.
// ---------------------------------------------------------------------------
package wecr_pkg;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTORE = 1'b1;

  localparam int CHAN_W  = 2;
  localparam int COUNT_W = 32;
  localparam int TOTAL_W = 64;

  typedef struct packed {
    logic                       req_type;
    logic [CHAN_W-1:0]          channel;
    logic [COUNT_W-1:0]         raw_count;
    logic signed [TOTAL_W-1:0]  restore_total;
  } req_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0]          out_channel;
    logic signed [TOTAL_W-1:0]  energy_total;
    logic signed [COUNT_W-1:0]  step_delta;
    logic                       was_seed;
  } rsp_word_t;

  // one memory entry per channel
  typedef struct packed {
    logic [COUNT_W-1:0] prev_sample;
    logic [TOTAL_W-1:0] total;
  } entry_t;

  // outcome of one read-modify-write
  typedef struct packed {
    entry_t             entry;
    logic [COUNT_W-1:0] delta;
    logic               seeded;
  } upd_t;

endpackage

// ===== rtl/wrapping_energy_counter_accumulator.sv =====
// ---------------------------------------------------------------------------
// wrapping_energy_counter_accumulator
// Per-channel 64-bit energy totals fed by samples of wrapping 32-bit counters.
// ---------------------------------------------------------------------------
// Request channel (req_valid/req_ready/req): a counter sample or a restore of
// a saved total for one channel. Response channel (rsp_valid/rsp_ready/rsp):
// exactly one word per request, in order, carrying the channel's total after
// the request, the signed delta added and whether the sample only seeded.
// Totals and previous samples sit in a one-port-write, one-port-read RAM with
// a registered read; seed-pending and written flags are flip-flops per channel.
// Flow: the edge that accepts a request also reads the RAM; the update stage
// then writes the new entry back and loads the response register together.
// Throughput: one request per cycle while rsp does not stall; a write to the
// channel read in the same cycle is forwarded from a bypass register.
// Reset: every total reads as zero and every channel awaits a seeding sample;
// no clearing pass is needed. Channels at or above NUM_CHANNELS leave state
// alone and answer with a zero total.
// When rsp stalls, the response register holds, the update stage holds its
// word and req_ready drops once both are full.
// ---------------------------------------------------------------------------
module wrapping_energy_counter_accumulator #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  wecr_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output wecr_pkg::rsp_word_t rsp
);
  import wecr_pkg::*;

  localparam int IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ENTRY_W = $bits(entry_t);

  // update stage
  logic             s1_valid;
  req_word_t        s1_req;
  logic             s1_fwd_hit;
  entry_t           s1_fwd_data;
  logic             s1_fire;
  logic             s1_in_range;
  logic [IDX_W-1:0] s1_idx;

  logic [NUM_CHANNELS-1:0] needs_seed;
  logic [NUM_CHANNELS-1:0] written;

  logic             req_fire;
  logic [IDX_W-1:0] req_idx;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           base;
  upd_t             upd;
  logic             wr_en;

  assign req_fire  = req_valid && req_ready;
  assign s1_fire   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !rst && (!s1_valid || s1_fire);

  assign req_idx     = IDX_W'(req.channel);
  assign s1_idx      = IDX_W'(s1_req.channel);
  assign s1_in_range = 32'(s1_req.channel) < NUM_CHANNELS;
  assign wr_en       = s1_fire && s1_in_range;

  wecr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_idx),
    .wdata (upd.entry),
    .re    (req_fire),
    .raddr (req_idx),
    .rdata (ram_rdata)
  );

  // newest copy of the entry: bypass, then RAM, else reset value
  always_comb begin
    base = '0;
    if (s1_in_range) begin
      if (s1_fwd_hit) begin
        base = s1_fwd_data;
      end else if (written[s1_idx]) begin
        base = entry_t'(ram_rdata);
      end
    end
  end

  wecr_update u_update (
    .req        (s1_req),
    .needs_seed (s1_in_range ? needs_seed[s1_idx] : 1'b0),
    .base       (base),
    .upd        (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      rsp_valid  <= 1'b0;
      needs_seed <= '1;
      written    <= '0;
    end else begin
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (wr_en) begin
        written[s1_idx] <= 1'b1;
        case (s1_req.req_type)
          REQ_RESTORE: needs_seed[s1_idx] <= 1'b1;
          REQ_SAMPLE:  needs_seed[s1_idx] <= 1'b0;
          default:     needs_seed[s1_idx] <= needs_seed[s1_idx];
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_req      <= req;
      // the read at this edge misses a write landing at the same edge
      s1_fwd_hit  <= wr_en && (s1_idx == req_idx);
      s1_fwd_data <= upd.entry;
    end
    if (s1_fire) begin
      rsp.out_channel  <= s1_req.channel;
      rsp.energy_total <= s1_in_range ? upd.entry.total : '0;
      rsp.step_delta   <= s1_in_range ? upd.delta : '0;
      rsp.was_seed     <= s1_in_range && upd.seeded;
    end
  end

endmodule

// ===== rtl/wecr_ram.sv =====
// ---------------------------------------------------------------------------
// wecr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module wecr_ram #(
  parameter int WIDTH  = 96,
  parameter int DEPTH  = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/wecr_update.sv =====
// ---------------------------------------------------------------------------
// wecr_update
// Per-word update: seeding, restore, or wrap-aware delta accumulation.
// ---------------------------------------------------------------------------
module wecr_update (
  input  wecr_pkg::req_word_t req,
  input  logic                needs_seed,
  input  wecr_pkg::entry_t    base,
  output wecr_pkg::upd_t      upd
);
  import wecr_pkg::*;

  logic [COUNT_W-1:0] diff;

  // unsigned difference modulo 2^32, read as signed
  assign diff = req.raw_count - base.prev_sample;

  always_comb begin
    upd = '{entry: base, delta: '0, seeded: 1'b0};
    case (req.req_type)
      REQ_RESTORE: begin
        upd.entry.total = req.restore_total;
      end
      REQ_SAMPLE: begin
        upd.entry.prev_sample = req.raw_count;
        if (needs_seed) begin
          upd.seeded = 1'b1;
        end else begin
          upd.delta       = diff;
          upd.entry.total = base.total + {{(TOTAL_W-COUNT_W){diff[COUNT_W-1]}}, diff};
        end
      end
      default: begin
        upd = '{entry: base, delta: '0, seeded: 1'b0};
      end
    endcase
  end

endmodule
